>>> sv/kphr_pkg.sv
// ----------------------------------------------------------------------------
// kphr_pkg
// Shared types, codes and constants for the key press/hold/release engine.
// ----------------------------------------------------------------------------
package kphr_pkg;

  localparam int KEY_W   = 4;
  localparam int KIND_W  = 2;
  localparam int CODE_W  = 8;
  localparam int HOLD_W  = 16;
  localparam int RATE_W  = 8;
  localparam int SUS_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [HOLD_W-1:0] HOLD_START_RST = 16'd100;
  localparam logic [RATE_W-1:0] REPEAT_RATE_RST = 8'd15;
  localparam logic [SUS_W-1:0]  SUSTAIN_RST = 8'd30;

  typedef enum logic [KIND_W-1:0] {
    EVT_PRESS   = 2'd0,
    EVT_HOLD    = 2'd1,
    EVT_RELEASE = 2'd2
  } evt_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOUCH_HOLD_START  = 3'd0,
    CFG_TOUCH_REPEAT_RATE = 3'd1,
    CFG_TOUCH_SUSTAIN     = 3'd2,
    CFG_RF_HOLD_START     = 3'd3,
    CFG_RF_REPEAT_RATE    = 3'd4,
    CFG_RF_SUSTAIN        = 3'd5
  } cfg_idx_t;

  localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
  localparam logic [KEY_W-1:0] KEY_UP    = 4'd1;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 4'd2;
  localparam logic [KEY_W-1:0] KEY_ONOFF = 4'd3;
  localparam logic [KEY_W-1:0] KEY_MODE  = 4'd4;

  typedef struct packed {
    logic [KEY_W-1:0] key_id;
    evt_kind_t        kind;
    logic             last;
  } result_t;

  function automatic logic [KEY_W-1:0] remote_to_key(input logic [CODE_W-1:0] code);
    logic [KEY_W-1:0] k;
    case (code)
      8'h04, 8'h1F: k = KEY_UP;
      8'h05, 8'h4C: k = KEY_DOWN;
      8'h1A, 8'h79: k = KEY_ONOFF;
      8'h01, 8'h3D: k = KEY_MODE;
      default:      k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

>>> sv/key_press_hold_release_engine.sv
// ----------------------------------------------------------------------------
// key_press_hold_release_engine
// Turns 10 ms key ticks from touch and remote sources into press, hold and
// release words, with a small result queue toward the output.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | touch_key, rf_valid, rf_code, machine_error
//   out_    | output    | out_valid/out_stall| key_id, event_kind, last_of_run
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One tick word is taken per cycle while in_stall is low; its state update is done
// in the cycle it is accepted and its zero to two result words enter a
// four-entry queue. The queue drains one word per cycle while out_stall is low,
// so the two results of a tick leave one after the other. in_stall rises while
// fewer than two queue slots are free. rst_n (synchronous) clears key state,
// queue and registers to their defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
module key_press_hold_release_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kphr_pkg::KEY_W-1:0]        in_touch_key,
  input  logic                              in_rf_valid,
  input  logic [kphr_pkg::CODE_W-1:0]       in_rf_code,
  input  logic                              in_machine_error,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kphr_pkg::KEY_W-1:0]        out_key_id,
  output logic [kphr_pkg::KIND_W-1:0]       out_event_kind,
  output logic                              out_last_of_run,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kphr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kphr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [kphr_pkg::HOLD_W-1:0] t_hold_start_r, rf_hold_start_r;
  logic [kphr_pkg::RATE_W-1:0] t_repeat_rate_r, rf_repeat_rate_r;
  logic [kphr_pkg::SUS_W-1:0]  t_sustain_r, rf_sustain_r;

  logic [kphr_pkg::KEY_W-1:0]  active_key_r, active_key_nxt;
  logic                        from_remote_r, from_remote_nxt;
  logic [kphr_pkg::SUS_W-1:0]  sustain_left_r, sustain_left_nxt;
  logic [kphr_pkg::HOLD_W-1:0] held_ticks_r, held_ticks_nxt;
  logic [kphr_pkg::RATE_W-1:0] repeat_ticks_r, repeat_ticks_nxt;

  kphr_pkg::result_t           q_r [kphr_pkg::Q_DEPTH];
  logic [kphr_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [kphr_pkg::Q_CNT_W-1:0] cnt_r;

  logic                        in_acc, out_acc;
  logic [kphr_pkg::KEY_W-1:0]  remote_key, offered;
  logic [kphr_pkg::HOLD_W-1:0] hs;
  logic [kphr_pkg::RATE_W-1:0] rr;
  logic [1:0]                  n_res;
  kphr_pkg::result_t           res_a, res_b;
  logic [kphr_pkg::Q_PTR_W-1:0] wr_ptr_p1;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = cnt_r > kphr_pkg::Q_CNT_W'(kphr_pkg::Q_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign cfg_ready = 1'b1;
  assign out_key_id      = q_r[rd_ptr_r].key_id;
  assign out_event_kind  = q_r[rd_ptr_r].kind;
  assign out_last_of_run = q_r[rd_ptr_r].last;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  assign remote_key = in_rf_valid ? kphr_pkg::remote_to_key(in_rf_code) : kphr_pkg::KEY_NONE;
  assign offered    = (in_touch_key != kphr_pkg::KEY_NONE) ? in_touch_key : remote_key;

  always_comb begin
    active_key_nxt   = active_key_r;
    from_remote_nxt  = from_remote_r;
    sustain_left_nxt = sustain_left_r;
    held_ticks_nxt   = held_ticks_r;
    repeat_ticks_nxt = repeat_ticks_r;
    n_res = 2'd0;
    res_a = '{key_id: kphr_pkg::KEY_NONE, kind: kphr_pkg::EVT_PRESS, last: 1'b0};
    res_b = res_a;
    hs = '0;
    rr = '0;
    if (in_machine_error) begin
      active_key_nxt   = kphr_pkg::KEY_NONE;
      from_remote_nxt  = 1'b0;
      sustain_left_nxt = '0;
      held_ticks_nxt   = '0;
      repeat_ticks_nxt = '0;
    end else begin
      if (offered != kphr_pkg::KEY_NONE) begin
        if (active_key_r == kphr_pkg::KEY_NONE) begin
          active_key_nxt   = offered;
          held_ticks_nxt   = '0;
          repeat_ticks_nxt = '0;
          from_remote_nxt  = (in_touch_key == kphr_pkg::KEY_NONE);
          sustain_left_nxt = from_remote_nxt ? rf_sustain_r : t_sustain_r;
          res_a = '{key_id: offered, kind: kphr_pkg::EVT_PRESS, last: 1'b1};
          n_res = 2'd1;
        end else if (offered == active_key_r) begin
          sustain_left_nxt = from_remote_r ? rf_sustain_r : t_sustain_r;
        end
      end
      if (active_key_nxt != kphr_pkg::KEY_NONE) begin
        if (sustain_left_nxt != '0) begin
          hs = from_remote_nxt ? rf_hold_start_r : t_hold_start_r;
          rr = from_remote_nxt ? rf_repeat_rate_r : t_repeat_rate_r;
          sustain_left_nxt = sustain_left_nxt - 1'b1;
          if (held_ticks_nxt != '1) held_ticks_nxt = held_ticks_nxt + 1'b1;
          if (held_ticks_nxt >= hs) begin
            if (repeat_ticks_nxt != '1) repeat_ticks_nxt = repeat_ticks_nxt + 1'b1;
            if (repeat_ticks_nxt >= rr) begin
              repeat_ticks_nxt = '0;
              res_b = '{key_id: active_key_nxt, kind: kphr_pkg::EVT_HOLD, last: 1'b1};
              n_res = n_res + 2'd1;
            end
          end
        end else begin
          res_b = '{key_id: active_key_nxt, kind: kphr_pkg::EVT_RELEASE, last: 1'b1};
          n_res = n_res + 2'd1;
          active_key_nxt  = kphr_pkg::KEY_NONE;
          held_ticks_nxt  = '0;
          from_remote_nxt = 1'b0;
        end
      end
      // mark the first of two results as not last, or pack a single result into the first slot
      if (n_res == 2'd2) begin
        res_a.last = 1'b0;
      end else if (n_res == 2'd1 && res_b.last) begin
        res_a = res_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_hold_start_r   <= kphr_pkg::HOLD_START_RST;
      t_repeat_rate_r  <= kphr_pkg::REPEAT_RATE_RST;
      t_sustain_r      <= kphr_pkg::SUSTAIN_RST;
      rf_hold_start_r  <= kphr_pkg::HOLD_START_RST;
      rf_repeat_rate_r <= kphr_pkg::REPEAT_RATE_RST;
      rf_sustain_r     <= kphr_pkg::SUSTAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kphr_pkg::CFG_TOUCH_HOLD_START:  t_hold_start_r   <= cfg_data;
        kphr_pkg::CFG_TOUCH_REPEAT_RATE: t_repeat_rate_r  <= cfg_data[kphr_pkg::RATE_W-1:0];
        kphr_pkg::CFG_TOUCH_SUSTAIN:     t_sustain_r      <= cfg_data[kphr_pkg::SUS_W-1:0];
        kphr_pkg::CFG_RF_HOLD_START:     rf_hold_start_r  <= cfg_data;
        kphr_pkg::CFG_RF_REPEAT_RATE:    rf_repeat_rate_r <= cfg_data[kphr_pkg::RATE_W-1:0];
        kphr_pkg::CFG_RF_SUSTAIN:        rf_sustain_r     <= cfg_data[kphr_pkg::SUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_key_r   <= kphr_pkg::KEY_NONE;
      from_remote_r  <= 1'b0;
      sustain_left_r <= '0;
      held_ticks_r   <= '0;
      repeat_ticks_r <= '0;
    end else if (in_acc) begin
      active_key_r   <= active_key_nxt;
      from_remote_r  <= from_remote_nxt;
      sustain_left_r <= sustain_left_nxt;
      held_ticks_r   <= held_ticks_nxt;
      repeat_ticks_r <= repeat_ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      q_r[wr_ptr_r] <= res_a;
      if (n_res == 2'd2) q_r[wr_ptr_p1] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) wr_ptr_r <= wr_ptr_r + kphr_pkg::Q_PTR_W'(n_res);
      if (out_acc) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (in_acc ? kphr_pkg::Q_CNT_W'(n_res) : '0)
                     - kphr_pkg::Q_CNT_W'(out_acc);
    end
  end

endmodule

>>> sv/kphr_checker.sv
// ----------------------------------------------------------------------------
// kphr_checker
// Port-level checks for the key press/hold/release engine, bound to the top.
// ----------------------------------------------------------------------------
module kphr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [kphr_pkg::KEY_W-1:0]        out_key_id,
  input logic [kphr_pkg::KIND_W-1:0]       out_event_kind,
  input logic                              out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_id)
      && $stable(out_event_kind) && $stable(out_last_of_run))
    else $error("stalled output word changed");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result queue");

  a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_id != kphr_pkg::KEY_NONE)
    else $error("result word without key");

  a_press_not_last_then_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid && out_last_of_run)
    else $error("run of results not closed by second word");

endmodule

bind key_press_hold_release_engine kphr_checker u_kphr_checker (.*);
